// ----- hdl/scp_pkg.sv -----
// ----------------------------------------------------------------------------
// scp_pkg: shared types, constants and functions of the sine commutation PWM
// Angle constants, sector codes, stage bundles, angle wrap and sine folding,
// and the elaboration-time builder of the quarter-wave sine table.
// ----------------------------------------------------------------------------
package scp_pkg;

   // Field widths
   localparam int ANGLE_W    = 12;
   localparam int ANGLE_SW   = 14;
   localparam int SPEED_W    = 12;
   localparam int TORQUE_W   = 12;
   localparam int DUTY_W     = 12;
   localparam int SINE_W     = 15;
   localparam int PROD_W     = SINE_W + TORQUE_W;
   localparam int CSR_DATA_W = 12;

   // Scale and angle range
   localparam int FULL_SCALE  = 2400;
   localparam int ANGLE_STEPS = 3600;

   // Quarter-wave sine table
   localparam int ROM_DEPTH = 901;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);

   typedef logic signed [ANGLE_SW-1:0] angle_wide_type;

   localparam angle_wide_type ANGLE_STEPS_W      = ANGLE_SW'(ANGLE_STEPS);
   localparam angle_wide_type FIELD_OFFSET       = 14'sd900;
   localparam angle_wide_type THIRD_TURN         = 14'sd1200;
   localparam angle_wide_type TWO_THIRDS_TURN    = 14'sd2400;
   localparam angle_wide_type SINE_PERIOD        = 14'sd3600;
   localparam angle_wide_type QUARTER_TURN       = 14'sd900;
   localparam angle_wide_type HALF_TURN          = 14'sd1800;
   localparam angle_wide_type THREE_QUARTER_TURN = 14'sd2700;

   // Correction passes that bring any step or load sum back into range
   localparam int WRAP_SPAN   = 7043;
   localparam int WRAP_PASSES = (WRAP_SPAN + ANGLE_STEPS - 1) / ANGLE_STEPS;

   // Item action codes
   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_LOAD = 1'b1
   } action_type;

   // Register indexes
   typedef enum logic {
      CSR_SPEED_STEP = 1'b0,
      CSR_TORQUE     = 1'b1
   } csr_index_type;

   localparam int CSR_INDEX_W = $bits(csr_index_type);

   typedef struct packed {
      logic                  we;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   // Which two phases carry sine, by 120-degree sector of the field angle
   typedef enum logic [1:0] {
      SEC_AC,
      SEC_AB,
      SEC_BC,
      SEC_NONE
   } sector_type;

   typedef struct packed {
      logic [ROM_AW-1:0] addr;
      logic              neg;
   } fold_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] field;
      logic               turn;
      sector_type         sector;
   } meta_type;

   // Angle stage output: one tick item on its way to the sine lookup
   typedef struct packed {
      logic              valid;
      meta_type          meta;
      logic [ROM_AW-1:0] x_addr;
      logic [ROM_AW-1:0] y_addr;
      logic              x_neg;
      logic              y_neg;
   } angle_bundle_type;

   typedef logic [SINE_W-1:0] sine_table_type [ROM_DEPTH];

   // Bring a sum into 0..ANGLE_STEPS-1
   function automatic logic [ANGLE_W-1:0] wrap_angle(input angle_wide_type v);
      angle_wide_type r;
      r = v;
      for (int i = 0; i < WRAP_PASSES; i++) begin
         if (r < 0) begin
            r = r + ANGLE_STEPS_W;
         end else if (r >= ANGLE_STEPS_W) begin
            r = r - ANGLE_STEPS_W;
         end
      end
      return r[ANGLE_W-1:0];
   endfunction

   // Reduce an offset angle to one period and fold it onto the quarter wave
   function automatic fold_type sine_fold(input angle_wide_type a);
      angle_wide_type r;
      angle_wide_type t;
      fold_type       f;
      r = a;
      if (r < 0) begin
         r = r + SINE_PERIOD;
      end else if (r >= SINE_PERIOD) begin
         r = r - SINE_PERIOD;
      end
      if (r <= QUARTER_TURN) begin
         t     = r;
         f.neg = 1'b0;
      end else if (r <= HALF_TURN) begin
         t     = HALF_TURN - r;
         f.neg = 1'b0;
      end else if (r <= THREE_QUARTER_TURN) begin
         t     = r - HALF_TURN;
         f.neg = 1'b1;
      end else begin
         t     = SINE_PERIOD - r;
         f.neg = 1'b1;
      end
      f.addr = t[ROM_AW-1:0];
      return f;
   endfunction

   // Fixed-point Taylor series constants (Q60)
   localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam logic [63:0] THETA_STEP = PI_Q60 / 64'd1800;
   localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;
   localparam logic [63:0] ROUND_BIT  = 64'h0000008000000000;

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah;
      logic [63:0] al;
      logic [63:0] bh;
      logic [63:0] bl;
      logic [63:0] mid;
      ah  = a >> 32;
      al  = {32'h0, a[31:0]};
      bh  = b >> 32;
      bl  = {32'h0, b[31:0]};
      mid = ah * bl + al * bh + ((al * bl) >> 32);
      return (ah * bh * 64'd16) + (mid >> 28);
   endfunction

   // round(32767 * sin(x * pi / 1800)) for x in 0..900
   function automatic sine_table_type build_sine_table();
      sine_table_type     tbl;
      logic [63:0]        theta;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      for (int x = 0; x < ROM_DEPTH; x++) begin
         theta = 64'(x) * THETA_STEP;
         t2    = mul_q60(theta, theta);
         term  = theta;
         sum   = signed'(theta);
         for (int n = 1; n <= 12; n++) begin
            term = mul_q60(term, t2) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         if (sum > signed'(ONE_Q60)) begin
            sum = signed'(ONE_Q60);
         end
         v      = (unsigned'(sum) >> 20) * 64'd32767;
         tbl[x] = SINE_W'((v + ROUND_BIT) >> 40);
      end
      return tbl;
   endfunction

endpackage

// ----- hdl/scp_if.sv -----
// ----------------------------------------------------------------------------
// scp_if: item channels of the sine commutation PWM
// Request channel (tick or angle load) and response channel (phase duties).
// ----------------------------------------------------------------------------
interface scp_req_if import scp_pkg::*;;
   logic               valid;
   logic               ready;
   logic               action;
   logic [ANGLE_W-1:0] phase_value;

   modport source(output valid, output action, output phase_value, input ready);
   modport sink(input valid, input action, input phase_value, output ready);
endinterface

interface scp_rsp_if import scp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  duty_a;
   logic [DUTY_W-1:0]  duty_b;
   logic [DUTY_W-1:0]  duty_c;
   logic [ANGLE_W-1:0] field_angle;
   logic               turn_done;

   modport source(output valid, output duty_a, output duty_b, output duty_c,
                  output field_angle, output turn_done, input ready);
   modport sink(input valid, input duty_a, input duty_b, input duty_c,
                input field_angle, input turn_done, output ready);
endinterface

// ----- hdl/scp_angle.sv -----
// ----------------------------------------------------------------------------
// scp_angle: rotor angle state and field angle stage
// Takes request items, advances or loads the rotor angle, registers the field
// angle and folds the two active phase angles onto the quarter-wave table.
// ----------------------------------------------------------------------------
module scp_angle import scp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   scp_req_if.sink          req,
   input  csr_write_type    csr,
   input  logic             s2_ready,
   output angle_bundle_type ang
);

   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [SPEED_W-1:0] speed_in;
   logic [ANGLE_W-1:0]        rotor_ff;
   logic [ANGLE_W-1:0]        rotor_in;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [ANGLE_W-1:0]        s1_field_ff;
   logic [ANGLE_W-1:0]        s1_field_in;
   logic                      s1_turn_ff;
   logic                      s1_turn_in;

   logic           accept;
   logic           is_load;
   angle_wide_type step_sum;
   angle_wide_type field_w;
   angle_wide_type x_angle;
   angle_wide_type y_angle;
   sector_type     sector;
   fold_type       x_fold;
   fold_type       y_fold;

   // Take an item whenever stage one is empty or moves on
   assign req.ready = !s1_valid_ff || s2_ready;
   assign accept    = req.valid && req.ready;
   assign is_load   = (action_type'(req.action) == ACT_LOAD);

   // Speed register write
   always_comb begin
      speed_in = speed_ff;
      if (csr.we && csr.index == CSR_SPEED_STEP) begin
         speed_in = signed'(csr.data[SPEED_W-1:0]);
      end
   end

   // Advance the rotor by one step, or load it
   always_comb begin
      step_sum    = angle_wide_type'({2'b00, rotor_ff}) +
                    angle_wide_type'(speed_ff);
      s1_turn_in  = s1_turn_ff;
      s1_field_in = s1_field_ff;
      rotor_in    = rotor_ff;
      if (accept) begin
         s1_turn_in  = (step_sum < 0) || (step_sum >= ANGLE_STEPS_W);
         s1_field_in = wrap_angle(step_sum + FIELD_OFFSET);
         if (is_load) begin
            rotor_in = wrap_angle(angle_wide_type'({2'b00, req.phase_value}));
         end else begin
            rotor_in = wrap_angle(step_sum);
         end
      end
   end

   // Hold stage one until the lookup stage takes it
   always_comb begin
      if (accept && !is_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= '0;
         rotor_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         speed_ff    <= speed_in;
         rotor_ff    <= rotor_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_field_ff <= s1_field_in;
      s1_turn_ff  <= s1_turn_in;
   end

   // Pick the sector and the two phase angles that carry sine
   always_comb begin
      field_w = angle_wide_type'({2'b00, s1_field_ff});
      priority if (field_w < THIRD_TURN) begin
         sector = SEC_AC;
      end else if (field_w < TWO_THIRDS_TURN) begin
         sector = SEC_AB;
      end else if (field_w < SINE_PERIOD) begin
         sector = SEC_BC;
      end else begin
         sector = SEC_NONE;
      end
      x_angle = (sector == SEC_AB) ? (field_w - TWO_THIRDS_TURN) : field_w;
      y_angle = (sector == SEC_BC) ? (field_w - TWO_THIRDS_TURN) : (field_w - THIRD_TURN);
      x_fold  = sine_fold(x_angle);
      y_fold  = sine_fold(y_angle);
   end

   // Lane X is negated outside sector AC, lane Y only inside it
   always_comb begin
      ang.valid       = s1_valid_ff;
      ang.meta.field  = s1_field_ff;
      ang.meta.turn   = s1_turn_ff;
      ang.meta.sector = sector;
      ang.x_addr      = x_fold.addr;
      ang.y_addr      = y_fold.addr;
      ang.x_neg       = x_fold.neg ^ (sector != SEC_AC);
      ang.y_neg       = y_fold.neg ^ (sector == SEC_AC);
   end

endmodule

// ----- hdl/scp_sine_rom.sv -----
// ----------------------------------------------------------------------------
// scp_sine_rom: quarter-wave sine table, two registered read ports
// Q0.15 values of sine for 0 to 90 degrees in tenths of a degree.
// ----------------------------------------------------------------------------
module scp_sine_rom import scp_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [ROM_AW-1:0] x_addr,
   input  logic [ROM_AW-1:0] y_addr,
   output logic [SINE_W-1:0] x_sine,
   output logic [SINE_W-1:0] y_sine
);

   localparam sine_table_type SINE_TABLE = build_sine_table();

   logic [SINE_W-1:0] x_sine_ff;
   logic [SINE_W-1:0] y_sine_ff;

   // Read both lanes, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         x_sine_ff <= SINE_TABLE[x_addr];
         y_sine_ff <= SINE_TABLE[y_addr];
      end
   end

   assign x_sine = x_sine_ff;
   assign y_sine = y_sine_ff;

endmodule

// ----- hdl/scp_duty.sv -----
// ----------------------------------------------------------------------------
// scp_duty: torque scaling, clamp and response register
// Scales the two sine lanes by torque, clamps to full scale, places them on
// the phases of the sector and drives the response channel.
// ----------------------------------------------------------------------------
module scp_duty import scp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  csr_write_type     csr,
   input  angle_bundle_type  ang,
   input  logic [SINE_W-1:0] x_sine,
   input  logic [SINE_W-1:0] y_sine,
   output logic              s2_ready,
   scp_rsp_if.source         rsp
);

   logic [TORQUE_W-1:0] torque_ff;
   logic [TORQUE_W-1:0] torque_in;

   logic     s2_valid_ff;
   logic     s2_valid_in;
   meta_type s2_meta_ff;
   meta_type s2_meta_in;
   logic     s2_x_pos_ff;
   logic     s2_x_pos_in;
   logic     s2_y_pos_ff;
   logic     s2_y_pos_in;

   logic              s3_valid_ff;
   logic              s3_valid_in;
   meta_type          s3_meta_ff;
   meta_type          s3_meta_in;
   logic [PROD_W-1:0] s3_x_prod_ff;
   logic [PROD_W-1:0] s3_x_prod_in;
   logic [PROD_W-1:0] s3_y_prod_ff;
   logic [PROD_W-1:0] s3_y_prod_in;

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [DUTY_W-1:0]  duty_a_ff;
   logic [DUTY_W-1:0]  duty_a_in;
   logic [DUTY_W-1:0]  duty_b_ff;
   logic [DUTY_W-1:0]  duty_b_in;
   logic [DUTY_W-1:0]  duty_c_ff;
   logic [DUTY_W-1:0]  duty_c_in;
   logic [ANGLE_W-1:0] field_ff;
   logic [ANGLE_W-1:0] field_in;
   logic               turn_ff;
   logic               turn_in;

   logic              out_ready;
   logic              s3_ready;
   logic [DUTY_W-1:0] x_duty;
   logic [DUTY_W-1:0] y_duty;

   // Drop the Q15 fraction and clamp to full scale
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [PROD_W-1:0] p);
      logic [PROD_W-SINE_W-1:0] d;
      d = p[PROD_W-1:SINE_W];
      if (32'(d) > FULL_SCALE) begin
         return DUTY_W'(FULL_SCALE);
      end
      return DUTY_W'(d);
   endfunction

   // Stall chain: each stage moves when the next one has room
   assign out_ready = !out_valid_ff || rsp.ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;

   // Torque register write
   always_comb begin
      torque_in = torque_ff;
      if (csr.we && csr.index == CSR_TORQUE) begin
         torque_in = csr.data[TORQUE_W-1:0];
      end
   end

   // Stage two: aligned with the sine read
   always_comb begin
      s2_valid_in = s2_ready ? ang.valid : s2_valid_ff;
      s2_meta_in  = s2_ready ? ang.meta : s2_meta_ff;
      s2_x_pos_in = s2_ready ? !ang.x_neg : s2_x_pos_ff;
      s2_y_pos_in = s2_ready ? !ang.y_neg : s2_y_pos_ff;
   end

   // Stage three: scale positive lanes by torque, zero the negative ones
   always_comb begin
      s3_valid_in  = s3_valid_ff;
      s3_meta_in   = s3_meta_ff;
      s3_x_prod_in = s3_x_prod_ff;
      s3_y_prod_in = s3_y_prod_ff;
      if (s3_ready) begin
         s3_valid_in  = s2_valid_ff;
         s3_meta_in   = s2_meta_ff;
         s3_x_prod_in = s2_x_pos_ff ?
                        ({{TORQUE_W{1'b0}}, x_sine} * {{SINE_W{1'b0}}, torque_ff}) : '0;
         s3_y_prod_in = s2_y_pos_ff ?
                        ({{TORQUE_W{1'b0}}, y_sine} * {{SINE_W{1'b0}}, torque_ff}) : '0;
      end
   end

   // Output register: place the lanes on the phases of the sector
   always_comb begin
      x_duty       = clamp_duty(s3_x_prod_ff);
      y_duty       = clamp_duty(s3_y_prod_ff);
      out_valid_in = out_valid_ff;
      duty_a_in    = duty_a_ff;
      duty_b_in    = duty_b_ff;
      duty_c_in    = duty_c_ff;
      field_in     = field_ff;
      turn_in      = turn_ff;
      if (out_ready) begin
         out_valid_in = s3_valid_ff;
         field_in     = s3_meta_ff.field;
         turn_in      = s3_meta_ff.turn;
         duty_a_in    = '0;
         duty_b_in    = '0;
         duty_c_in    = '0;
         unique case (s3_meta_ff.sector)
            SEC_AC: begin
               duty_a_in = x_duty;
               duty_c_in = y_duty;
            end
            SEC_AB: begin
               duty_a_in = x_duty;
               duty_b_in = y_duty;
            end
            SEC_BC: begin
               duty_b_in = x_duty;
               duty_c_in = y_duty;
            end
            SEC_NONE: begin
               duty_a_in = '0;
            end
            default: begin
               duty_a_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         torque_ff    <= '0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         torque_ff    <= torque_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_meta_ff   <= s2_meta_in;
      s2_x_pos_ff  <= s2_x_pos_in;
      s2_y_pos_ff  <= s2_y_pos_in;
      s3_meta_ff   <= s3_meta_in;
      s3_x_prod_ff <= s3_x_prod_in;
      s3_y_prod_ff <= s3_y_prod_in;
      duty_a_ff    <= duty_a_in;
      duty_b_ff    <= duty_b_in;
      duty_c_ff    <= duty_c_in;
      field_ff     <= field_in;
      turn_ff      <= turn_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.duty_a      = duty_a_ff;
   assign rsp.duty_b      = duty_b_ff;
   assign rsp.duty_c      = duty_c_ff;
   assign rsp.field_angle = field_ff;
   assign rsp.turn_done   = turn_ff;

endmodule

// ----- hdl/sine_commutation_pwm.sv -----
// ----------------------------------------------------------------------------
// sine_commutation_pwm: open-loop sinusoidal three-phase commutation
// Send one request item per PWM period on req_ch. A tick item (action 0)
// adds speed_step to the rotor angle, wrapping over one turn, and returns one
// response item on rsp_ch: three compare values, the field angle and a turn
// flag. A load item (action 1) sets the rotor angle and returns nothing.
// Registers speed_step (index 0) and torque (index 1) are written through
// csr_we, csr_index and csr_wdata; the user must write them while no item is
// in flight, which the block itself does not enforce. The accepting edge loads
// the angle stage; the sine read, torque multiply and output register follow,
// each registered, before the response shows on rsp_ch.
// Throughput: one item per cycle unless rsp_ch stalls; the sine table has two
// read ports, one for each active phase, so every item takes a single pass.
// Reset (synchronous, active high) clears the rotor angle, both registers and
// the pipeline. When the receiver holds rsp_ch.ready low the response holds
// and items keep entering until every stage is full; then req_ch.ready drops.
// ----------------------------------------------------------------------------
module sine_commutation_pwm import scp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   scp_req_if.sink                req_ch,
   scp_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_write_type     csr;
   angle_bundle_type  ang;
   logic              s2_ready;
   logic [SINE_W-1:0] x_sine;
   logic [SINE_W-1:0] y_sine;

   // Bundle the register write port
   always_comb begin
      csr.we    = csr_we;
      csr.index = csr_index_type'(csr_index);
      csr.data  = csr_wdata;
   end

   scp_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .csr      (csr),
      .s2_ready (s2_ready),
      .ang      (ang)
   );

   scp_sine_rom u_sine_rom (
      .clock  (clock),
      .en     (s2_ready),
      .x_addr (ang.x_addr),
      .y_addr (ang.y_addr),
      .x_sine (x_sine),
      .y_sine (y_sine)
   );

   scp_duty u_duty (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .ang      (ang),
      .x_sine   (x_sine),
      .y_sine   (y_sine),
      .s2_ready (s2_ready),
      .rsp      (rsp_ch)
   );

   // Compare values never exceed full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.duty_a <= DUTY_W'(FULL_SCALE) &&
                        rsp_ch.duty_b <= DUTY_W'(FULL_SCALE) &&
                        rsp_ch.duty_c <= DUTY_W'(FULL_SCALE)))
      else $error("duty above full scale");

   // One phase is always held at zero
   a_zero_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.duty_a == '0 || rsp_ch.duty_b == '0 ||
                        rsp_ch.duty_c == '0))
      else $error("no phase held at zero");

   // Field angle stays within one turn
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.field_angle) < ANGLE_STEPS))
      else $error("field angle out of range");

   // The pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule

// ----- verif/sine_commutation_pwm_tb.sv -----
// ----------------------------------------------------------------------------
// sine_commutation_pwm_tb: self-checking bench for the sine commutation PWM
// Drives tick and angle-load items through the request channel under random
// gaps and response stalls. It reprograms speed and torque between phases and
// checks every response against a sine-table model of the drive.
// ----------------------------------------------------------------------------
module sine_commutation_pwm_tb import scp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [DUTY_W-1:0]  duty_a;
      logic [DUTY_W-1:0]  duty_b;
      logic [DUTY_W-1:0]  duty_c;
      logic [ANGLE_W-1:0] field_angle;
      logic               turn_done;
   } drive_type;

   // Track rotor angle and registers, queue the drive each tick should produce
   class drive_scoreboard;
      int                 sine_lut [901];
      logic signed [11:0] speed_step;
      logic [11:0]        torque;
      int                 rotor_angle;
      drive_type          expected_drive [$];
      int                 mismatches;

      function new();
         sine_table_type tbl;
         // Fill the quarter wave from the fixed-point series values
         tbl = build_sine_table();
         for (int x = 0; x <= 900; x++) begin
            sine_lut[x] = int'(tbl[x]);
         end
         speed_step  = '0;
         torque      = '0;
         rotor_angle = 0;
         mismatches  = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [11:0] data);
         if (idx == CSR_SPEED_STEP) begin
            speed_step = data;
         end else begin
            torque = data;
         end
      endfunction

      // Fold any angle onto the quarter wave and apply the sign
      function int sine_of(int a);
         int r;
         r = a % 3600;
         if (r < 0) begin
            r += 3600;
         end
         if (r <= 900) return sine_lut[r];
         if (r <= 1800) return sine_lut[1800 - r];
         if (r <= 2700) return -sine_lut[r - 1800];
         return -sine_lut[3600 - r];
      endfunction

      function logic [DUTY_W-1:0] duty_of(int s);
         longint p;
         p = longint'(s) * longint'(torque);
         if (p <= 0) return '0;
         p = p >>> 15;
         if (p > FULL_SCALE) begin
            p = FULL_SCALE;
         end
         return DUTY_W'(p);
      endfunction

      // Advance the rotor on a tick and queue its drive; a load only sets the angle
      function void note_item(action_type act, logic [ANGLE_W-1:0] value);
         int        sum;
         int        f;
         drive_type d;
         if (act == ACT_LOAD) begin
            rotor_angle = int'(value) % 3600;
            return;
         end
         sum         = rotor_angle + int'(speed_step);
         d.turn_done = (sum < 0) || (sum >= 3600);
         rotor_angle = ((sum % 3600) + 3600) % 3600;
         f           = (rotor_angle + 900) % 3600;
         d.field_angle = ANGLE_W'(f);
         d.duty_a = '0;
         d.duty_b = '0;
         d.duty_c = '0;
         case (f / 600)
            0, 1: begin
               d.duty_a = duty_of(sine_of(f));
               d.duty_c = duty_of(-sine_of(f - 1200));
            end
            2, 3: begin
               d.duty_a = duty_of(-sine_of(f - 2400));
               d.duty_b = duty_of(sine_of(f - 1200));
            end
            default: begin
               d.duty_b = duty_of(-sine_of(f));
               d.duty_c = duty_of(sine_of(f - 2400));
            end
         endcase
         expected_drive.push_back(d);
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one response with the oldest queued drive
      task check_result(drive_type got);
         drive_type want;
         if (expected_drive.size() == 0) begin
            report($sformatf("unexpected response field_angle=%0d", got.field_angle));
            return;
         end
         want = expected_drive.pop_front();
         if (got.duty_a !== want.duty_a)
            report($sformatf("duty_a %0d, want %0d (field %0d)",
                             got.duty_a, want.duty_a, want.field_angle));
         if (got.duty_b !== want.duty_b)
            report($sformatf("duty_b %0d, want %0d (field %0d)",
                             got.duty_b, want.duty_b, want.field_angle));
         if (got.duty_c !== want.duty_c)
            report($sformatf("duty_c %0d, want %0d (field %0d)",
                             got.duty_c, want.duty_c, want.field_angle));
         if (got.field_angle !== want.field_angle)
            report($sformatf("field_angle %0d, want %0d",
                             got.field_angle, want.field_angle));
         if (got.turn_done !== want.turn_done)
            report($sformatf("turn_done %0b, want %0b (field %0d)",
                             got.turn_done, want.turn_done, want.field_angle));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   calm = 1'b0;

   scp_req_if req_ch ();
   scp_rsp_if rsp_ch ();

   drive_scoreboard sb = new();

   sine_commutation_pwm dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6ns clock = ~clock;

   // Mostly short gaps, now and then a long one; none while calm
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one item after a random gap and hold it until accepted
   task automatic send_item(action_type act, logic [ANGLE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.phase_value <= value;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(act, value);
   endtask

   // Drop valid, let every response come back and any load settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.expected_drive.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges
   task automatic start_phase(int speed, int trq);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_SPEED_STEP;
      csr_wdata <= CSR_DATA_W'(speed);
      @(posedge clock);
      sb.set_register(CSR_SPEED_STEP, CSR_DATA_W'(speed));
      csr_index <= CSR_TORQUE;
      csr_wdata <= CSR_DATA_W'(trq);
      @(posedge clock);
      sb.set_register(CSR_TORQUE, CSR_DATA_W'(trq));
      csr_we <= 1'b0;
   endtask

   // Stall the response side in random bursts
   initial begin
      int run;
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         run = $urandom_range(1, 24);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      drive_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.duty_a      = rsp_ch.duty_a;
         got.duty_b      = rsp_ch.duty_b;
         got.duty_c      = rsp_ch.duty_c;
         got.field_angle = rsp_ch.field_angle;
         got.turn_done   = rsp_ch.turn_done;
         sb.check_result(got);
      end
   end

   // Main sequence: directed corners, then random phases
   initial begin
      int edge_load [8];
      int speeds [6];
      int torques [6];
      action_type act;
      logic [ANGLE_W-1:0] value;
      edge_load = '{2700, 3299, 3300, 300, 900, 1500, 2100, 2699};
      speeds    = '{0, 2047, -2048, 1, 0, -7};
      torques   = '{0, 1, 4095, 0, 0, 4095};
      speeds[0]  = int'($urandom_range(0, 3600)) - 1800;
      torques[0] = $urandom_range(0, 4095);
      speeds[4]  = int'($urandom_range(0, 3600)) - 1800;
      torques[4] = $urandom_range(0, 4095);

      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_TICK;
      req_ch.phase_value <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SPEED_STEP;
      csr_wdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Tick with reset registers: zero torque, zero speed
      send_item(ACT_TICK, 12'hFFF);

      // Sector edges of the field angle at full torque
      start_phase(0, 4095);
      foreach (edge_load[i]) begin
         send_item(ACT_LOAD, ANGLE_W'(edge_load[i]));
         send_item(ACT_TICK, 12'hFFF);
      end

      // Wrap below zero, then land exactly on zero
      start_phase(-1800, 4095);
      send_item(ACT_LOAD, '0);
      send_item(ACT_TICK, '0);
      send_item(ACT_TICK, '0);

      // Out-of-range load, then wrap at exactly one turn
      start_phase(1800, FULL_SCALE);
      send_item(ACT_LOAD, 12'hFFF);
      send_item(ACT_TICK, '0);
      send_item(ACT_LOAD, 12'd1800);
      send_item(ACT_TICK, '0);

      // Random phases, one of them without any idling
      foreach (speeds[p]) begin
         start_phase(speeds[p], torques[p]);
         calm = (p == 2);
         for (int i = 0; i < 16; i++) begin
            act   = ($urandom_range(0, 99) < 22) ? ACT_LOAD : ACT_TICK;
            value = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(3600, 4095))
                                                : ANGLE_W'($urandom_range(0, 3599));
            send_item(act, value);
         end
         calm = 1'b0;
      end

      wait_drained();
      if (sb.mismatches == 0) begin
         $display("sine_commutation_pwm: match");
      end else begin
         $display("sine_commutation_pwm: mismatch");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2ms;
      $display("sine_commutation_pwm: mismatch");
      $finish;
   end

endmodule
